FILE: rtl/tqb_pkg.sv
// shared types, codes and helpers of the textured quad batcher
package tqb_pkg;

  localparam int DEF_MAX_QUADS    = 256;
  localparam int DEF_SLOT_COUNT   = 32;
  localparam int INDICES_PER_QUAD = 6;

  // dividend and divisor widths of the coordinate divider
  localparam int NUM_W = 36;
  localparam int DEN_W = 17;
  localparam int NDC_W = 24;

  localparam logic [NUM_W-1:0] SAT_MAG = NUM_W'(8388608);

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_BIND   = 2'd1;
  localparam logic [1:0] KIND_DRAW   = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BLANK  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLUSH_BIND,
    S_FLUSH_DRAW,
    S_LOOKUP,
    S_VERT
  } state_t;

  // clamp the rounded magnitude and apply the sign
  function automatic logic [NDC_W-1:0] sat_q16(input logic [NUM_W-1:0] q, input logic neg);
    logic [NUM_W-1:0] m;
    logic [NUM_W-1:0] nm;
    m  = (q > SAT_MAG) ? SAT_MAG : q;
    nm = NUM_W'(0) - m;
    if (neg) return nm[NDC_W-1:0];
    if (m == SAT_MAG) return {1'b0, {(NDC_W-1){1'b1}}};
    return m[NDC_W-1:0];
  endfunction

endpackage

FILE: rtl/tqb_cell.sv
// one texture slot cell: holds a name, compares it, shifts toward slot one
module tqb_cell (
  input  logic        clk,
  input  logic        load,
  input  logic        shift,
  input  logic [31:0] load_name,
  input  logic [31:0] shift_name,
  input  logic [31:0] key,
  output logic [31:0] name,
  output logic        hit
);

  always_ff @(posedge clk) begin
    if (load) begin
      name <= load_name;
    end else if (shift) begin
      name <= shift_name;
    end
  end

  assign hit = (name == key);

endmodule

FILE: rtl/tqb_div.sv
// restoring divider, one quotient bit per cycle
module tqb_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tqb_pkg::NUM_W-1:0]    num,
  input  logic [tqb_pkg::DEN_W-1:0]    den,
  output logic                         busy,
  output logic [tqb_pkg::NUM_W-1:0]    quo
);

  localparam int CW = $clog2(tqb_pkg::NUM_W + 1);

  logic [tqb_pkg::NUM_W-1:0] n;
  logic [tqb_pkg::DEN_W-1:0] d;
  logic [tqb_pkg::DEN_W-1:0] rem;
  logic [CW-1:0]             cnt;
  logic [tqb_pkg::DEN_W:0]   trial;
  logic                      qbit;
  logic [tqb_pkg::DEN_W:0]   diff;

  always_comb begin
    trial = {rem, n[tqb_pkg::NUM_W-1]};
    qbit  = (trial >= {1'b0, d});
    diff  = trial - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(tqb_pkg::NUM_W);
      n    <= num;
      d    <= den;
      rem  <= '0;
    end else if (busy) begin
      rem  <= qbit ? diff[tqb_pkg::DEN_W-1:0] : trial[tqb_pkg::DEN_W-1:0];
      n    <= {n[tqb_pkg::NUM_W-2:0], qbit};
      cnt  <= cnt - CW'(1);
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  assign quo = n;

endmodule

FILE: rtl/textured_quad_batcher.sv
// top level: batches textured quads into slot bindings, draws and vertices
//
// input stream (s_axis): one transaction per request; tuser is the operation
// (draw quad or end of frame), tdata carries texture name, position and size.
// output stream (m_axis): bindings, draw commands and vertices; tuser is the
// kind, tlast marks the final result of a request.
// configuration: cfg_we writes cfg_data into register cfg_index (0 width,
// 1 height, 2 blank texture name); the user writes only while idle; not enforced.
// a draw gives its first vertex once the 36 step bit-serial dividers (four in
// parallel, one per edge coordinate) are done, then one vertex per cycle while
// the receiver is ready.
// a flush ahead of a draw runs while the dividers work; an end of frame flush
// gives a binding for slot zero (the blank name) and one per used slot, then
// the draw command; the slot names leave by shifting down the chain of cells.
// end of frame with an empty batch gives nothing.
// one request is in flight at a time; s_axis_tready is high only when idle.
// a stalled receiver holds the output register; the block waits on it.
// reset (rst, synchronous) restores the default registers, empties the batch
// and sets the next free slot to one; slot names are undefined until written.
module textured_quad_batcher #(
  parameter int MAX_QUADS  = tqb_pkg::DEF_MAX_QUADS,
  parameter int SLOT_COUNT = tqb_pkg::DEF_SLOT_COUNT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // texture_name[31:0], pos_x[47:32], pos_y[63:48], size_w[79:64], size_h[95:80]
  input  logic [95:0]  s_axis_tdata,
  // operation[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // ndc_x[23:0], ndc_y[47:24], tex_u[48], tex_v[49], slot_index[54:50],
  // bound_name[86:55], batch_indices[97:87], zero[103:98]
  output logic [103:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int SW      = $clog2(SLOT_COUNT + 1);
  localparam int IW      = $clog2(SLOT_COUNT);
  localparam int MAX_IDX = MAX_QUADS * tqb_pkg::INDICES_PER_QUAD;
  localparam int PW      = $clog2(MAX_IDX + 1);

  tqb_pkg::state_t state, state_next;

  logic [15:0] screen_width, screen_height;
  logic [31:0] blank_name;

  logic [SW-1:0] next_free;
  logic [PW-1:0] pending;
  logic [SW-1:0] fi;
  logic [1:0]    corner;
  logic          op_end;
  logic [31:0]   tex;
  logic [IW-1:0] slot;
  logic [3:0]    lane_neg;

  logic [23:0] o_x, o_y;
  logic        o_u, o_v, o_last;
  logic [4:0]  o_slot;
  logic [31:0] o_name;
  logic [10:0] o_batch;
  logic [1:0]  o_kind;

  logic        accept, out_free, emit, cell_shift, need_flush, found;
  logic [IW-1:0] hit_idx;
  logic [1:0]  e_kind;
  logic [23:0] e_x, e_y;
  logic        e_u, e_v, e_last;
  logic [4:0]  e_slot;
  logic [31:0] e_name;
  logic [10:0] e_batch;

  logic [31:0] names [1:SLOT_COUNT-1];
  logic [SLOT_COUNT-1:1] hits, cell_load;

  logic [3:0]  div_start;
  logic [3:0]  lane_busy;
  logic [tqb_pkg::NUM_W-1:0] div_num [4];
  logic [tqb_pkg::NUM_W-1:0] div_quo [4];
  logic [tqb_pkg::DEN_W-1:0] div_den [4];
  logic [3:0]  num_neg;
  logic [23:0] ndc [4];
  logic        div_busy;

  // coordinate numerators
  logic [15:0] w_eff, h_eff;
  logic signed [18:0] x0, y0, x1, y1;
  logic signed [18:0] nums [4];

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    w_eff = (screen_width == 16'd0) ? 16'd1 : screen_width;
    h_eff = (screen_height == 16'd0) ? 16'd1 : screen_height;
    x0 = 19'(signed'(s_axis_tdata[47:32]));
    y0 = 19'(signed'(s_axis_tdata[63:48]));
    x1 = x0 + 19'(signed'(s_axis_tdata[79:64]));
    y1 = y0 + 19'(signed'(s_axis_tdata[95:80]));
    nums[0] = (x0 <<< 1) - signed'({3'b0, w_eff});
    nums[1] = (x1 <<< 1) - signed'({3'b0, w_eff});
    nums[2] = signed'({3'b0, h_eff}) - (y0 <<< 1);
    nums[3] = signed'({3'b0, h_eff}) - (y1 <<< 1);
  end

  // rounded quotient: (2*mag*65536 + d) / (2*d)
  for (genvar g = 0; g < 4; g++) begin : g_div
    logic [18:0] mag;
    logic [tqb_pkg::DEN_W-1:0] den_lane;
    assign den_lane     = (g < 2) ? {w_eff, 1'b0} : {h_eff, 1'b0};
    assign num_neg[g]   = nums[g][18];
    assign mag          = num_neg[g] ? 19'(-nums[g]) : 19'(nums[g]);
    assign div_num[g]   = tqb_pkg::NUM_W'({mag[17:0], 17'b0})
                        + tqb_pkg::NUM_W'(den_lane[tqb_pkg::DEN_W-1:1]);
    assign div_den[g]   = den_lane;
    assign div_start[g] = accept && (s_axis_tuser[0] == tqb_pkg::OP_DRAW);
    tqb_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start[g]),
      .num   (div_num[g]),
      .den   (div_den[g]),
      .busy  (lane_busy[g]),
      .quo   (div_quo[g])
    );
    assign ndc[g] = tqb_pkg::sat_q16(div_quo[g], lane_neg[g]);
  end

  assign div_busy = |lane_busy;

  // chain of slot cells, slot one at the head
  for (genvar k = 1; k < SLOT_COUNT; k++) begin : g_cell
    logic [31:0] from_right;
    if (k == SLOT_COUNT - 1) begin : g_tail
      assign from_right = '0;
    end else begin : g_link
      assign from_right = names[k+1];
    end
    assign cell_load[k] = (state == tqb_pkg::S_LOOKUP) && !found && (next_free == SW'(k));
    tqb_cell u_cell (
      .clk        (clk),
      .load       (cell_load[k]),
      .shift      (cell_shift),
      .load_name  (tex),
      .shift_name (from_right),
      .key        (tex),
      .name       (names[k]),
      .hit        (hits[k])
    );
  end

  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int k = SLOT_COUNT - 1; k >= 1; k--) begin
      if (hits[k] && (SW'(k) < next_free)) begin
        found   = 1'b1;
        hit_idx = IW'(k);
      end
    end
  end

  assign need_flush = (pending >= PW'(MAX_IDX)) || (next_free > SW'(SLOT_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tqb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    emit          = 1'b0;
    cell_shift    = 1'b0;
    e_kind        = tqb_pkg::KIND_VERTEX;
    e_x           = '0;
    e_y           = '0;
    e_u           = 1'b0;
    e_v           = 1'b0;
    e_slot        = '0;
    e_name        = '0;
    e_batch       = '0;
    e_last        = 1'b0;
    case (state)
      tqb_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          if (s_axis_tuser[0] == tqb_pkg::OP_END) begin
            if (pending != '0) state_next = tqb_pkg::S_FLUSH_BIND;
          end else begin
            state_next = need_flush ? tqb_pkg::S_FLUSH_BIND : tqb_pkg::S_LOOKUP;
          end
        end
      end
      tqb_pkg::S_FLUSH_BIND: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = tqb_pkg::KIND_BIND;
          e_slot     = 5'(fi);
          e_name     = (fi == '0) ? blank_name : names[1];
          cell_shift = (fi != '0);
          if (fi == next_free - SW'(1)) state_next = tqb_pkg::S_FLUSH_DRAW;
        end
      end
      tqb_pkg::S_FLUSH_DRAW: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = tqb_pkg::KIND_DRAW;
          e_batch    = 11'(pending);
          e_last     = op_end;
          state_next = op_end ? tqb_pkg::S_IDLE : tqb_pkg::S_LOOKUP;
        end
      end
      tqb_pkg::S_LOOKUP: begin
        state_next = tqb_pkg::S_VERT;
      end
      tqb_pkg::S_VERT: begin
        if (out_free && !div_busy) begin
          emit   = 1'b1;
          e_kind = tqb_pkg::KIND_VERTEX;
          e_x    = corner[1] ? ndc[1] : ndc[0];
          e_y    = (corner[1] ^ corner[0]) ? ndc[3] : ndc[2];
          e_u    = corner[1];
          e_v    = ~(corner[1] ^ corner[0]);
          e_slot = 5'(slot);
          e_last = (corner == 2'd3);
          if (corner == 2'd3) state_next = tqb_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tqb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 16'd1920;
      screen_height <= 16'd1080;
      blank_name    <= '0;
      next_free     <= SW'(1);
      pending       <= '0;
      fi            <= '0;
      corner        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tqb_pkg::REG_WIDTH:  screen_width  <= cfg_data[15:0];
          tqb_pkg::REG_HEIGHT: screen_height <= cfg_data[15:0];
          tqb_pkg::REG_BLANK:  blank_name    <= cfg_data;
          default: ;
        endcase
      end
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (accept) begin
        fi     <= '0;
        corner <= '0;
      end
      if (state == tqb_pkg::S_FLUSH_BIND && emit) fi <= fi + SW'(1);
      if (state == tqb_pkg::S_FLUSH_DRAW && emit) begin
        pending   <= '0;
        next_free <= SW'(1);
      end
      if (state == tqb_pkg::S_LOOKUP && !found) next_free <= next_free + SW'(1);
      if (state == tqb_pkg::S_VERT && emit) begin
        corner <= corner + 2'd1;
        if (corner == 2'd3) pending <= pending + PW'(tqb_pkg::INDICES_PER_QUAD);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_end   <= s_axis_tuser[0];
      tex      <= s_axis_tdata[31:0];
      lane_neg <= num_neg;
    end
    if (state == tqb_pkg::S_LOOKUP) begin
      slot <= found ? hit_idx : next_free[IW-1:0];
    end
    if (emit) begin
      o_kind  <= e_kind;
      o_x     <= e_x;
      o_y     <= e_y;
      o_u     <= e_u;
      o_v     <= e_v;
      o_slot  <= e_slot;
      o_name  <= e_name;
      o_batch <= e_batch;
      o_last  <= e_last;
    end
  end

  assign m_axis_tdata = {6'b0, o_batch, o_name, o_slot, o_v, o_u, o_y, o_x};
  assign m_axis_tuser = o_kind;
  assign m_axis_tlast = o_last;

  a_next_free_range: assert property (@(posedge clk) disable iff (rst)
    (next_free != '0) && (next_free <= SW'(SLOT_COUNT)))
    else $error("next free slot out of range");

  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    pending <= PW'(MAX_IDX))
    else $error("pending index count beyond batch size");

  a_last_vertex: assert property (@(posedge clk) disable iff (rst)
    (state == tqb_pkg::S_VERT) && emit && (corner == 2'd3)
    |=> m_axis_tvalid && m_axis_tlast)
    else $error("fourth vertex not marked last");

  a_vertex_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == tqb_pkg::S_VERT) && emit |-> !div_busy)
    else $error("vertex sent before division finished");

endmodule
